@@ hdl/bfa_pkg.sv @@
// Shared types and constants for the first-fit run allocator.
// Used by bfa_word_scan, bfa_map_mem and bitmap_first_fit_run_allocator.
package bfa_pkg;

  // Occupancy map is held as words of this many slots
  localparam int WORD_W = 32;
  localparam int WB     = $clog2(WORD_W);

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF   = 256;
  localparam int MAX_RUN_DEF = 32;

  // Field widths
  localparam int CMD_W   = 1;
  localparam int LEN_W   = 6;
  localparam int START_W = 8;
  localparam int POS_W   = 9;
  localparam int CFG_W   = 9;

  // Reset value of the slots-in-use register
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // Free-gap counter saturates at the largest encodable run
  localparam int GAP_W   = LEN_W;
  localparam int GAP_MAX = (1 << GAP_W) - 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [LEN_W-1:0]   run_length;
    logic [START_W-1:0] start_slot;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] slot_position;
    logic             success;
    logic             map_empty;
  } out_item_t;

  // Result of evaluating one map word during the search
  typedef struct packed {
    logic             hit;  // a long enough gap ends in this word
    logic [WB-1:0]    idx;  // lowest bit at which such a gap ends
    logic [GAP_W-1:0] gap;  // free run carried into the next word
  } scan_res_t;

endpackage

@@ hdl/bfa_word_scan.sv @@
// One-word gap search for the first-fit allocator.
// Depends on bfa_pkg.
module bfa_word_scan #(
  parameter int XW = 10
) (
  input  logic [bfa_pkg::WORD_W-1:0] word,
  input  logic [XW-1:0]              base,
  input  logic [XW-1:0]              limit,
  input  logic [bfa_pkg::GAP_W-1:0]  gap_in,
  input  logic [bfa_pkg::LEN_W-1:0]  len,
  output bfa_pkg::scan_res_t         res
);
  import bfa_pkg::*;

  localparam int CW = GAP_W + 2;

  logic [WORD_W-1:0]             free_v;
  logic [WORD_W-1:0]             win;
  logic [WORD_W-1:0]             pre;
  logic [WORD_W-1:0]             reach;
  logic [WORD_W-1:0]             hit;
  logic [LEN_W-1:0][WORD_W-1:0]  run_v;
  logic [XW-1:0]                 rem;
  logic                          taken;
  logic [CW-1:0]                 top;
  logic [CW-1:0]                 gap_sum;

  // Free slots of this word that lie below the slot limit
  always_comb begin
    rem = limit - base;
    for (int i = 0; i < WORD_W; i++) begin
      free_v[i] = ~word[i] & (XW'(i) < rem);
    end
  end

  // run_v[k][i]: 2^k free slots end at bit i (doubling)
  always_comb begin
    run_v[0] = free_v;
    for (int k = 1; k < LEN_W; k++) begin
      run_v[k] = run_v[k-1] & (run_v[k-1] << (1 << (k-1)));
    end
  end

  // Compose a window of exactly len slots from the power-of-two pieces
  always_comb begin
    win   = '0;
    taken = 1'b0;
    for (int k = LEN_W - 1; k >= 0; k--) begin
      if (len[k]) begin
        if (taken) begin
          win = run_v[k] & (win << (1 << k));
        end else begin
          win = run_v[k];
        end
        taken = 1'b1;
      end
    end
  end

  // Gaps that start in an earlier word: all free from bit 0, carry long enough
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      pre[i]   = &(free_v | ({WORD_W{1'b1}} << (i + 1)));
      reach[i] = (CW'(gap_in) + CW'(i + 1)) >= CW'(len);
    end
    hit = win | (pre & reach);
  end

  // Lowest hit, and the free run left at the top of the word
  always_comb begin
    res.hit = |hit;
    res.idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit[i]) begin
        res.idx = WB'(i);
      end
    end
    top = CW'(WORD_W);
    for (int i = 0; i < WORD_W; i++) begin
      if (!free_v[i]) begin
        top = CW'(WORD_W - 1 - i);
      end
    end
    gap_sum = CW'(gap_in) + CW'(WORD_W);
    if (&free_v) begin
      res.gap = (gap_sum > CW'(GAP_MAX)) ? GAP_W'(GAP_MAX) : gap_sum[GAP_W-1:0];
    end else begin
      res.gap = top[GAP_W-1:0];
    end
  end

endmodule

@@ hdl/bfa_map_mem.sv @@
// Occupancy map storage: word memory with registered read,
// per-word valid and non-zero flags. Depends on bfa_pkg.
module bfa_map_mem #(
  parameter int NWORDS = 8,
  parameter int WA_W   = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [WA_W-1:0]           rd_addr,
  output logic [bfa_pkg::WORD_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [WA_W-1:0]           wr_addr,
  input  logic [bfa_pkg::WORD_W-1:0] wr_data,
  output logic                      map_empty
);
  import bfa_pkg::*;

  logic [WORD_W-1:0] mem [NWORDS];
  logic [NWORDS-1:0] valid_r;
  logic [NWORDS-1:0] nz_r;
  logic [WORD_W-1:0] rd_word_r;
  logic              rd_valid_r;

  // Per-word flags: a word never written reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      nz_r    <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
      nz_r[wr_addr]    <= |wr_data;
    end
  end

  // Memory array and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word_r  <= mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
  end

  assign rd_data   = rd_valid_r ? rd_word_r : '0;
  assign map_empty = ~|nz_r;

endmodule

@@ hdl/bitmap_first_fit_run_allocator.sv @@
// First-fit contiguous run allocator over an occupancy bitmap.
// Depends on bfa_pkg, bfa_word_scan and bfa_map_mem.
//
// Input channel (in_valid/in_ready/in_data) takes one command per
// transaction: allocate a run of run_length slots, or free run_length
// slots from start_slot. Each command gives one result transaction on
// out_valid/out_ready/out_data: start slot or slot count, success flag and
// whether the whole map is empty afterwards. cfg_wr_en/cfg_wr_data write
// the slots-in-use register; write it only while idle.
// One command is worked on at a time; in_ready is high when idle.
// A command passes through S_PREP, one S_SCAN step per 32-slot word read
// by the first-fit search (at most 8 for 256 slots, none for free), one
// S_MOD step per word rewritten (at most 2), then S_FIN. The map lives in
// a single-port-write memory of 32-bit words read once per cycle, so the
// word count sets the rate; in_ready rises as the result is registered.
// Reset clears the map at once through per-word valid flags and sets
// slots-in-use to 256. A stalled result is held in the output register;
// the block finishes the command and waits there before taking the next.
module bitmap_first_fit_run_allocator #(
  parameter int SLOTS   = bfa_pkg::SLOTS_DEF,
  parameter int MAX_RUN = bfa_pkg::MAX_RUN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [bfa_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bfa_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bfa_pkg::out_item_t       out_data
);
  import bfa_pkg::*;

  localparam int NWORDS  = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int WA_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SI_W    = WA_W + WB;
  localparam int XW      = ((SI_W > POS_W) ? SI_W : POS_W) + 1;
  localparam int LEN_CAP = (MAX_RUN > GAP_MAX) ? GAP_MAX : MAX_RUN;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_MOD,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;

  logic [CFG_W-1:0]   cfg_r;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [WA_W-1:0]    scur_r, scur_nxt;
  logic [GAP_W-1:0]   gap_r, gap_nxt;
  logic [WA_W-1:0]    wcur_r, wcur_nxt;
  logic [XW-1:0]      lo_r, lo_nxt;
  logic [XW-1:0]      hi_r, hi_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               ok_r, ok_nxt;

  logic [XW-1:0]      limit;
  logic [XW-1:0]      limit_m1;
  logic [XW-1:0]      hi_m1;
  logic [WA_W-1:0]    slast;
  logic [WA_W-1:0]    wlast;
  logic [XW-1:0]      start_x;
  logic [LEN_W-1:0]   free_len;
  logic [XW-1:0]      free_end;
  logic [XW-1:0]      scan_base;
  logic [XW-1:0]      fstart;
  logic [XW-1:0]      slot_i;
  logic [WORD_W-1:0]  run_mask;
  logic [WORD_W-1:0]  mod_word;

  logic [WA_W-1:0]    rd_addr;
  logic [WORD_W-1:0]  rd_data;
  logic               wr_en;
  logic [WORD_W-1:0]  wr_data;
  logic               map_empty;
  scan_res_t          scan;

  // Slots-in-use register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // Effective limit and derived word bounds
  always_comb begin
    limit     = (XW'(cfg_r) > XW'(SLOTS)) ? XW'(SLOTS) : XW'(cfg_r);
    limit_m1  = limit - XW'(1);
    slast     = limit_m1[WB +: WA_W];
    hi_m1     = hi_r - XW'(1);
    wlast     = hi_m1[WB +: WA_W];
    start_x   = XW'(start_r);
    free_len  = (len_r > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len_r;
    free_end  = start_x + XW'(free_len);
    scan_base = XW'({scur_r, {WB{1'b0}}});
    fstart    = scan_base + XW'(scan.idx) + XW'(1) - XW'(len_r);
  end

  // Set or clear mask for the word being rewritten
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      slot_i      = XW'({wcur_r, WB'(i)});
      run_mask[i] = (slot_i >= lo_r) && (slot_i < hi_r);
    end
    mod_word = (cmd_r == CMD_ALLOC) ? (rd_data | run_mask) : (rd_data & ~run_mask);
  end

  bfa_word_scan #(
    .XW (XW)
  ) u_scan (
    .word   (rd_data),
    .base   (scan_base),
    .limit  (limit),
    .gap_in (gap_r),
    .len    (len_r),
    .res    (scan)
  );

  bfa_map_mem #(
    .NWORDS (NWORDS),
    .WA_W   (WA_W)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wcur_r),
    .wr_data   (wr_data),
    .map_empty (map_empty)
  );

  // Command sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    start_nxt     = start_r;
    scur_nxt      = scur_r;
    gap_nxt       = gap_r;
    wcur_nxt      = wcur_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pos_nxt       = pos_r;
    ok_nxt        = ok_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_data       = mod_word;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_item_nxt  = out_item_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.command;
          len_nxt   = in_data.run_length;
          start_nxt = in_data.start_slot;
          state_nxt = S_PREP;
        end
      end

      // Sort out trivial cases, start the search or the clear
      S_PREP: begin
        pos_nxt   = '0;
        ok_nxt    = 1'b0;
        state_nxt = S_FIN;
        if (cmd_r == CMD_ALLOC) begin
          pos_nxt = POS_W'(limit);
          if ((len_r != '0) && (len_r <= LEN_W'(LEN_CAP)) && (limit != '0)) begin
            scur_nxt  = '0;
            gap_nxt   = '0;
            rd_addr   = '0;
            state_nxt = S_SCAN;
          end
        end else if (start_x < limit) begin
          ok_nxt = 1'b1;
          if (len_r != '0) begin
            lo_nxt    = start_x;
            hi_nxt    = (free_end < limit) ? free_end : limit;
            wcur_nxt  = start_x[WB +: WA_W];
            rd_addr   = start_x[WB +: WA_W];
            state_nxt = S_MOD;
          end
        end
      end

      // One word per cycle; next read issued alongside
      S_SCAN: begin
        if (scan.hit) begin
          pos_nxt   = POS_W'(fstart);
          ok_nxt    = 1'b1;
          lo_nxt    = fstart;
          hi_nxt    = fstart + XW'(len_r);
          wcur_nxt  = fstart[WB +: WA_W];
          rd_addr   = fstart[WB +: WA_W];
          state_nxt = S_MOD;
        end else if (scur_r == slast) begin
          pos_nxt   = POS_W'(limit);
          ok_nxt    = 1'b0;
          state_nxt = S_FIN;
        end else begin
          scur_nxt = scur_r + WA_W'(1);
          gap_nxt  = scan.gap;
          rd_addr  = scur_r + WA_W'(1);
        end
      end

      // Read-modify-write of each word the run touches
      S_MOD: begin
        wr_en = 1'b1;
        if (wcur_r == wlast) begin
          state_nxt = S_FIN;
        end else begin
          wcur_nxt = wcur_r + WA_W'(1);
          rd_addr  = wcur_r + WA_W'(1);
        end
      end

      // Hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.slot_position = pos_r;
          out_item_nxt.success       = ok_r;
          out_item_nxt.map_empty     = map_empty;
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  // Working registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    len_r   <= len_nxt;
    start_r <= start_nxt;
    scur_r  <= scur_nxt;
    gap_r   <= gap_nxt;
    wcur_r  <= wcur_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    pos_r   <= pos_nxt;
    ok_r    <= ok_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // A granted run lies wholly below the limit
  a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && cmd_r == CMD_ALLOC && ok_r) |->
      (XW'(pos_r) + XW'(len_r) <= limit))
    else $error("allocated run exceeds slot limit");

  // After a granted allocation the map cannot be empty
  a_alloc_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && cmd_r == CMD_ALLOC && ok_r) |-> !map_empty)
    else $error("map reported empty after allocation");

  // Free always reports position zero
  a_free_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && cmd_r == CMD_FREE) |-> (pos_r == '0))
    else $error("free reported non-zero position");

  // Rewrite stays within the run's words and the run is not empty
  a_mod_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> ((wcur_r <= wlast) && (lo_r < hi_r)))
    else $error("rewrite outside run");

  // Search never passes the last word below the limit
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scur_r <= slast))
    else $error("search beyond slot limit");

endmodule
